### rtl/llsq_pkg.sv
// Shared types, codes and reset values for the link level stability qualifier.
`timescale 1ns / 1ps

package llsq_pkg;

    // Default number of transmitters tracked.
    localparam int NUM_TX_DEF = 8;

    // Fixed field widths.
    localparam int TX_W    = 3;
    localparam int LEVEL_W = 16;
    localparam int CNT_W   = 8;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Qualifying mode codes.
    localparam logic [MODE_W-1:0] MODE_UNKNOWN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SETTLING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOW      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STABLE   = 2'd3;

    // Receiver kinds.
    localparam logic [1:0] RX_EMPTY   = 2'd0;
    localparam logic [1:0] RX_SINGLE  = 2'd1;
    localparam logic [1:0] RX_DUAL    = 2'd2;
    localparam logic [1:0] RX_SIX_WAY = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RX_TYPE            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RLL_LOW_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RLL_HIGH_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOOD_FLOOR         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_DELTA       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_COUNT_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_COUNT_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AGC_GAIN_MODE      = 3'd7;

    // Marker stored when a level has not been read.
    localparam logic signed [LEVEL_W-1:0] UNREAD_LEVEL = 16'sh8000;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // Configuration register set.
    typedef struct packed {
        logic [1:0]                 rx_type;
        logic signed [LEVEL_W-1:0]  rll_low_limit;
        logic signed [LEVEL_W-1:0]  rll_high_limit;
        logic signed [LEVEL_W-1:0]  good_floor;
        logic [LEVEL_W-1:0]         stable_delta;
        logic [CNT_W-1:0]           low_count_limit;
        logic [CNT_W-1:0]           stable_count_limit;
        logic [1:0]                 agc_gain_mode;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rx_type:            RX_EMPTY,
        rll_low_limit:      -16'sd1000,
        rll_high_limit:     16'sd1000,
        good_floor:         -16'sd1000,
        stable_delta:       16'd50,
        low_count_limit:    8'd3,
        stable_count_limit: 8'd5,
        agc_gain_mode:      2'd3
    };

    // One input item.
    typedef struct packed {
        logic [TX_W-1:0]            tx_index;
        logic signed [LEVEL_W-1:0]  link_level;
        logic [TX_W-1:0]            active_tx;
        logic                       tx_present;
        logic                       tx_asleep;
    } item_t;

    // Per-transmitter table entry.
    typedef struct packed {
        logic signed [LEVEL_W-1:0]  last_level;
        logic [MODE_W-1:0]          mode;
        logic [CNT_W-1:0]           steady_count;
        logic [CNT_W-1:0]           low_count;
        logic                       low_alarm_flag;
        logic                       high_alarm_flag;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        last_level:      UNREAD_LEVEL,
        mode:            MODE_UNKNOWN,
        steady_count:    '0,
        low_count:       '0,
        low_alarm_flag:  1'b0,
        high_alarm_flag: 1'b0
    };

    // One result item.
    typedef struct packed {
        logic signed [LEVEL_W-1:0]  stored_level;
        logic [MODE_W-1:0]          qualify_mode;
        logic                       low_alarm;
        logic                       high_alarm;
        logic                       reapply_gain;
    } result_t;

endpackage

### rtl/llsq_update.sv
// Next-entry and result logic for one link level sample.
`timescale 1ns / 1ps

module llsq_update #(
    parameter int NUM_TX = llsq_pkg::NUM_TX_DEF
) (
    input  llsq_pkg::cfg_t    cfg,
    input  llsq_pkg::item_t   item,
    input  llsq_pkg::entry_t  entry,
    output llsq_pkg::entry_t  entry_new,
    output logic              entry_wr,
    output llsq_pkg::result_t result
);

    logic                                   in_range;
    logic                                   not_active;
    logic                                   hold;
    logic                                   agc_entry;
    logic [llsq_pkg::CNT_W-1:0]             cnt;
    logic signed [llsq_pkg::LEVEL_W:0]      diff;
    logic [llsq_pkg::LEVEL_W:0]             diff_abs;
    logic                                   steady;
    logic                                   reapply;

    assign in_range   = 32'(item.tx_index) < 32'(NUM_TX);
    assign not_active = (cfg.rx_type == llsq_pkg::RX_SIX_WAY) &&
                        (item.active_tx != item.tx_index);
    assign agc_entry  = (cfg.rx_type == llsq_pkg::RX_DUAL) ? item.tx_index[0] : 1'b0;

    // Absolute change from the previously stored level.
    assign diff     = (llsq_pkg::LEVEL_W+1)'(item.link_level) -
                      (llsq_pkg::LEVEL_W+1)'(entry.last_level);
    assign diff_abs = diff[llsq_pkg::LEVEL_W] ? (llsq_pkg::LEVEL_W+1)'(-diff)
                                              : (llsq_pkg::LEVEL_W+1)'(diff);
    assign steady   = (item.link_level > cfg.good_floor) &&
                      (diff_abs < {1'b0, cfg.stable_delta});

    // Qualification and alarm update for the addressed transmitter.
    always_comb begin
        entry_new = entry;
        hold      = 1'b0;
        reapply   = 1'b0;
        cnt       = '0;
        if (not_active) begin
            if (entry.mode != llsq_pkg::MODE_STABLE) begin
                entry_new.mode         = llsq_pkg::MODE_UNKNOWN;
                entry_new.steady_count = '0;
            end
        end else if (!item.tx_present || item.tx_asleep) begin
            entry_new.last_level = llsq_pkg::UNREAD_LEVEL;
        end else begin
            entry_new.last_level = item.link_level;
            if (entry.mode != llsq_pkg::MODE_STABLE) begin
                if (item.link_level < cfg.rll_low_limit) begin
                    entry_new.steady_count = '0;
                    entry_new.mode         = llsq_pkg::MODE_SETTLING;
                    if (entry.low_count < cfg.low_count_limit) begin
                        entry_new.low_count = entry.low_count + 1'b1;
                    end else begin
                        entry_new.mode = llsq_pkg::MODE_LOW;
                    end
                end else begin
                    // A pending low run or a mode other than settling restarts the count.
                    if (entry.mode == llsq_pkg::MODE_SETTLING && entry.low_count == '0) begin
                        cnt = entry.steady_count;
                    end
                    entry_new.low_count = '0;
                    if (steady) begin
                        cnt = (cnt == llsq_pkg::CNT_MAX) ? cnt : cnt + 1'b1;
                    end else begin
                        cnt = '0;
                    end
                    entry_new.steady_count = cnt;
                    if (cnt > cfg.stable_count_limit) begin
                        entry_new.mode = llsq_pkg::MODE_STABLE;
                    end else begin
                        entry_new.mode = llsq_pkg::MODE_SETTLING;
                        hold           = 1'b1;
                    end
                end
            end
            if (!hold) begin
                if ((entry_new.mode == llsq_pkg::MODE_STABLE ||
                     entry_new.mode == llsq_pkg::MODE_LOW) &&
                    item.link_level < cfg.rll_low_limit &&
                    item.link_level != llsq_pkg::UNREAD_LEVEL) begin
                    entry_new.low_alarm_flag = 1'b1;
                end else begin
                    entry_new.low_alarm_flag  = 1'b0;
                    reapply = entry.low_alarm_flag & cfg.agc_gain_mode[agc_entry];
                    entry_new.high_alarm_flag = (item.link_level > cfg.rll_high_limit) &&
                                                (item.link_level != llsq_pkg::UNREAD_LEVEL);
                end
            end
        end
    end

    // Out-of-range transmitters leave the table alone and report a fixed result.
    always_comb begin
        entry_wr = in_range;
        if (in_range) begin
            result.stored_level = entry_new.last_level;
            result.qualify_mode = entry_new.mode;
            result.low_alarm    = entry_new.low_alarm_flag;
            result.high_alarm   = entry_new.high_alarm_flag;
            result.reapply_gain = reapply;
        end else begin
            result.stored_level = llsq_pkg::UNREAD_LEVEL;
            result.qualify_mode = llsq_pkg::MODE_UNKNOWN;
            result.low_alarm    = 1'b0;
            result.high_alarm   = 1'b0;
            result.reapply_gain = 1'b0;
        end
    end

endmodule

### rtl/llsq_table.sv
// Per-transmitter state table in flip-flops, one read and one write port.
`timescale 1ns / 1ps

module llsq_table #(
    parameter int NUM_TX = llsq_pkg::NUM_TX_DEF,
    parameter int IDX_W  = (NUM_TX > 1) ? $clog2(NUM_TX) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IDX_W-1:0]  rd_idx,
    output llsq_pkg::entry_t  rd_entry,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  llsq_pkg::entry_t  wr_entry
);

    llsq_pkg::entry_t entry_reg [NUM_TX];

    // The read index may address past the table only for out-of-range items.
    assign rd_entry = (32'(rd_idx) < 32'(NUM_TX)) ? entry_reg[rd_idx] : llsq_pkg::ENTRY_RESET;

    // Reset returns every transmitter to its initial entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TX; i++) begin
                entry_reg[i] <= llsq_pkg::ENTRY_RESET;
            end
        end else if (wr_en && (32'(wr_idx) < 32'(NUM_TX))) begin
            entry_reg[wr_idx] <= wr_entry;
        end
    end

endmodule

### rtl/link_level_stability_qualifier.sv
// Top level: input register, table update, result register, configuration registers.
// Items pass from the input register into the result register once it is free.
// Throughput: one item per cycle while the result channel is not stalled; the single
// table read-modify-write between the input and result registers sets this figure.
// Reset (synchronous, active low) clears both pipeline stages, loads the
// configuration defaults and returns every transmitter entry to unknown/unread.
`timescale 1ns / 1ps

module link_level_stability_qualifier #(
    parameter int NUM_TX = llsq_pkg::NUM_TX_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [llsq_pkg::CFG_IDX_W-1:0]         cfg_wr_index,
    input  logic [llsq_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    // Sample input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [llsq_pkg::TX_W-1:0]              s_tx_index,
    input  logic signed [llsq_pkg::LEVEL_W-1:0]    s_link_level,
    input  logic [llsq_pkg::TX_W-1:0]              s_active_tx,
    input  logic                                   s_tx_present,
    input  logic                                   s_tx_asleep,
    // Result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [llsq_pkg::LEVEL_W-1:0]    m_stored_level,
    output logic [llsq_pkg::MODE_W-1:0]            m_qualify_mode,
    output logic                                   m_low_alarm,
    output logic                                   m_high_alarm,
    output logic                                   m_reapply_gain
);

    localparam int IDX_W = (NUM_TX > 1) ? $clog2(NUM_TX) : 1;

    llsq_pkg::cfg_t     cfg_reg;
    logic               in_valid_reg;
    llsq_pkg::item_t    in_item_reg;
    logic               out_valid_reg;
    llsq_pkg::result_t  out_result_reg;

    logic               in_valid_next;
    logic               out_valid_next;
    logic               advance;
    logic [IDX_W-1:0]   tx_idx;
    llsq_pkg::entry_t   cur_entry;
    llsq_pkg::entry_t   new_entry;
    logic               entry_wr;
    llsq_pkg::result_t  upd_result;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= llsq_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                llsq_pkg::REG_RX_TYPE:            cfg_reg.rx_type <= cfg_wr_data[1:0];
                llsq_pkg::REG_RLL_LOW_LIMIT:      cfg_reg.rll_low_limit <= cfg_wr_data;
                llsq_pkg::REG_RLL_HIGH_LIMIT:     cfg_reg.rll_high_limit <= cfg_wr_data;
                llsq_pkg::REG_GOOD_FLOOR:         cfg_reg.good_floor <= cfg_wr_data;
                llsq_pkg::REG_STABLE_DELTA:       cfg_reg.stable_delta <= cfg_wr_data;
                llsq_pkg::REG_LOW_COUNT_LIMIT:
                    cfg_reg.low_count_limit <= cfg_wr_data[llsq_pkg::CNT_W-1:0];
                llsq_pkg::REG_STABLE_COUNT_LIMIT:
                    cfg_reg.stable_count_limit <= cfg_wr_data[llsq_pkg::CNT_W-1:0];
                llsq_pkg::REG_AGC_GAIN_MODE:      cfg_reg.agc_gain_mode <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input stage moves on whenever the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.tx_index   <= s_tx_index;
            in_item_reg.link_level <= s_link_level;
            in_item_reg.active_tx  <= s_active_tx;
            in_item_reg.tx_present <= s_tx_present;
            in_item_reg.tx_asleep  <= s_tx_asleep;
        end
        if (advance) begin
            out_result_reg <= upd_result;
        end
    end

    assign tx_idx = IDX_W'(in_item_reg.tx_index);

    llsq_table #(
        .NUM_TX (NUM_TX),
        .IDX_W  (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (tx_idx),
        .rd_entry (cur_entry),
        .wr_en    (advance && entry_wr),
        .wr_idx   (tx_idx),
        .wr_entry (new_entry)
    );

    llsq_update #(
        .NUM_TX (NUM_TX)
    ) u_update (
        .cfg       (cfg_reg),
        .item      (in_item_reg),
        .entry     (cur_entry),
        .entry_new (new_entry),
        .entry_wr  (entry_wr),
        .result    (upd_result)
    );

    assign m_valid        = out_valid_reg;
    assign m_stored_level = out_result_reg.stored_level;
    assign m_qualify_mode = out_result_reg.qualify_mode;
    assign m_low_alarm    = out_result_reg.low_alarm;
    assign m_high_alarm   = out_result_reg.high_alarm;
    assign m_reapply_gain = out_result_reg.reapply_gain;

endmodule

### rtl/llsq_checker.sv
// Port-level checks for the link level stability qualifier, bound to the top level.
`timescale 1ns / 1ps

module llsq_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [llsq_pkg::LEVEL_W-1:0]   m_stored_level,
    input logic [llsq_pkg::MODE_W-1:0]           m_qualify_mode,
    input logic                                  m_low_alarm,
    input logic                                  m_reapply_gain
);

    // No result may appear in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_stored_level) &&
                                $stable(m_qualify_mode))
        else $error("stalled result changed");

    // A gain re-send only comes with the low alarm being cleared.
    a_reapply_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reapply_gain |-> !m_low_alarm)
        else $error("gain re-send while low alarm still set");

    // A gain re-send only comes from a qualified sample, never in unknown mode.
    a_reapply_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reapply_gain |-> m_qualify_mode != llsq_pkg::MODE_UNKNOWN)
        else $error("gain re-send in unknown mode");

endmodule

bind link_level_stability_qualifier llsq_checker u_llsq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_stored_level (m_stored_level),
    .m_qualify_mode (m_qualify_mode),
    .m_low_alarm    (m_low_alarm),
    .m_reapply_gain (m_reapply_gain)
);
